>>> rtl/pps_pkg.sv
package pps_pkg;

    localparam int DATA_W     = 8;
    localparam int LIMIT_W    = 16;
    localparam int STROBE_W   = 8;
    localparam int DELAY_W    = 16;
    localparam int SLEEP_W    = 16;
    localparam int WRITTEN_W  = 16;
    localparam int CMD_W      = 2;
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_RESET_PULSE_TICKS = 64;
    localparam int DEF_COUNT_WIDTH       = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT       = 3'd4;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_PAPER_OUT = 3'd1,
        ERR_OFFLINE   = 3'd2,
        ERR_FAULT     = 3'd3,
        ERR_INTR      = 3'd4
    } t_err;

    typedef struct packed {
        logic [LIMIT_W-1:0]  char_limit;
        logic [STROBE_W-1:0] strobe_wait;
        logic [DELAY_W-1:0]  retry_delay;
        logic [DELAY_W-1:0]  error_delay;
        logic                abort_on_error;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data_byte;
        logic              start_of_write;
        logic              slow_tick;
        logic              cancel;
        logic              not_busy;
        logic              paper_out;
        logic              selected;
        logic              no_fault;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]    data_lines;
        logic                 strobe_res;
        logic                 init_low;
        logic                 ready_res;
        logic                 byte_done;
        logic [ERR_W-1:0]     error_code;
        logic                 finished;
        logic [WRITTEN_W-1:0] written_count;
    } t_result;

endpackage

>>> rtl/parallel_printer_byte_sender.sv
// channel | valid      | ready      | payload
// input   | i_in_valid | o_in_ready | i_cmd .. i_no_fault, one port tick per beat
// output  | o_out_valid| i_out_ready| o_data_lines .. o_written_count, one per beat
// config  | i_cfg_we   | (none)     | i_cfg_idx, i_cfg_data
//
// One beat in per cycle while results are taken; a beat passes the input
// register, then the step logic into the result register, to become valid.
// While a result stalls on the output the input register takes one more beat,
// then o_in_ready drops until the result leaves.
// Synchronous active-low reset clears control state and config to defaults.
module parallel_printer_byte_sender #(
    parameter int RESET_PULSE_TICKS = pps_pkg::DEF_RESET_PULSE_TICKS,
    parameter int COUNT_WIDTH       = pps_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pps_pkg::CMD_W-1:0]         i_cmd,
    input  logic [pps_pkg::DATA_W-1:0]        i_data_byte,
    input  logic                              i_start_of_write,
    input  logic                              i_slow_tick,
    input  logic                              i_cancel,
    input  logic                              i_not_busy,
    input  logic                              i_paper_out,
    input  logic                              i_selected,
    input  logic                              i_no_fault,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pps_pkg::DATA_W-1:0]        o_data_lines,
    output logic                              o_strobe_res,
    output logic                              o_init_low,
    output logic                              o_ready_res,
    output logic                              o_byte_done,
    output logic [pps_pkg::ERR_W-1:0]         o_error_code,
    output logic                              o_finished,
    output logic [pps_pkg::WRITTEN_W-1:0]     o_written_count
);
    import pps_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item, stage_item;
    t_result res;
    logic    stage_valid, take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_limit     <= LIMIT_W'(1000);
            r_cfg.strobe_wait    <= STROBE_W'(1);
            r_cfg.retry_delay    <= DELAY_W'(40);
            r_cfg.error_delay    <= DELAY_W'(1000);
            r_cfg.abort_on_error <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHAR_LIMIT:  r_cfg.char_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_STROBE_WAIT: r_cfg.strobe_wait    <= i_cfg_data[STROBE_W-1:0];
                CFG_RETRY_DELAY: r_cfg.retry_delay    <= i_cfg_data[DELAY_W-1:0];
                CFG_ERROR_DELAY: r_cfg.error_delay    <= i_cfg_data[DELAY_W-1:0];
                CFG_ABORT:       r_cfg.abort_on_error <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.cmd            = i_cmd;
    assign in_item.data_byte      = i_data_byte;
    assign in_item.start_of_write = i_start_of_write;
    assign in_item.slow_tick      = i_slow_tick;
    assign in_item.cancel         = i_cancel;
    assign in_item.not_busy       = i_not_busy;
    assign in_item.paper_out      = i_paper_out;
    assign in_item.selected       = i_selected;
    assign in_item.no_fault       = i_no_fault;

    pps_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (take),
        .o_item  (stage_item)
    );

    pps_core #(
        .RESET_PULSE_TICKS (RESET_PULSE_TICKS),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (stage_valid),
        .o_take  (take),
        .i_item  (stage_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_data_lines    = res.data_lines;
    assign o_strobe_res    = res.strobe_res;
    assign o_init_low      = res.init_low;
    assign o_ready_res     = res.ready_res;
    assign o_byte_done     = res.byte_done;
    assign o_error_code    = res.error_code;
    assign o_finished      = res.finished;
    assign o_written_count = res.written_count;

endmodule

>>> rtl/pps_in_stage.sv
module pps_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pps_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output pps_pkg::t_item o_item
);
    import pps_pkg::*;

    logic  r_valid;
    t_item r_item;

    // refill in the same cycle the held beat moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/pps_core.sv
module pps_core #(
    parameter int RESET_PULSE_TICKS = pps_pkg::DEF_RESET_PULSE_TICKS,
    parameter int COUNT_WIDTH       = pps_pkg::DEF_COUNT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pps_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_take,
    input  pps_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output pps_pkg::t_result o_res
);
    import pps_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SLEEP_W-1:0] PULSE_TICKS = SLEEP_W'(RESET_PULSE_TICKS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POLL,
        PH_SETUP,
        PH_STROBE,
        PH_ERRSLEEP,
        PH_RETRYSLEEP,
        PH_RESET
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_poll, n_poll;
    logic [STROBE_W-1:0]    r_strobe, n_strobe;
    logic [SLEEP_W-1:0]     r_sleep, n_sleep;
    logic [DATA_W-1:0]      r_held, n_held;
    logic [WRITTEN_W-1:0]   r_written, n_written;
    t_err                   r_err, n_err;
    logic                   r_valid;
    t_result                r_res, n_res;

    logic [COUNT_WIDTH-1:0] poll_inc;
    logic [DELAY_W-1:0]     delay;
    logic [SLEEP_W-1:0]     slp;
    t_err                   cls;
    logic                   done, fin, init, drive;

    assign o_take  = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // fault class at a timeout: paper out wins, then offline, then fault line
    always_comb begin
        if (i_item.paper_out) begin
            cls = ERR_PAPER_OUT;
        end else if (!i_item.selected) begin
            cls = ERR_OFFLINE;
        end else if (!i_item.no_fault) begin
            cls = ERR_FAULT;
        end else begin
            cls = ERR_NONE;
        end
    end

    assign poll_inc = (r_poll < CMAX) ? r_poll + 1'b1 : r_poll;
    assign delay    = (r_phase == PH_ERRSLEEP) ? i_cfg.error_delay : i_cfg.retry_delay;
    assign slp      = (i_item.slow_tick && (r_sleep < delay)) ? r_sleep + 1'b1 : r_sleep;

    always_comb begin
        n_phase   = r_phase;
        n_poll    = r_poll;
        n_strobe  = r_strobe;
        n_sleep   = r_sleep;
        n_held    = r_held;
        n_written = r_written;
        n_err     = r_err;
        done      = 1'b0;
        fin       = 1'b0;
        init      = 1'b0;

        if (i_item.start_of_write) begin
            n_written = '0;
            n_err     = ERR_NONE;
        end

        if (i_item.cmd == CMD_RESET) begin
            n_sleep = SLEEP_W'(1);
            n_phase = (n_sleep >= PULSE_TICKS) ? PH_IDLE : PH_RESET;
            init    = 1'b1;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.cmd == CMD_BYTE) begin
                        n_held  = i_item.data_byte;
                        n_poll  = '0;
                        n_phase = PH_POLL;
                    end
                end
                PH_POLL: begin
                    n_poll = poll_inc;
                    if (i_item.not_busy) begin
                        n_strobe = '0;
                        n_phase  = PH_SETUP;
                    end else if ((CMP_W'(poll_inc) >= CMP_W'(i_cfg.char_limit))
                                 || (poll_inc == CMAX)) begin
                        if (cls != ERR_NONE) begin
                            n_err = cls;
                            if (i_cfg.abort_on_error) begin
                                fin     = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_sleep = '0;
                                n_phase = PH_ERRSLEEP;
                            end
                        end else if (i_item.cancel) begin
                            n_err   = ERR_INTR;
                            fin     = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_sleep = '0;
                            n_phase = PH_RETRYSLEEP;
                        end
                    end
                end
                PH_SETUP: begin
                    if (r_strobe >= i_cfg.strobe_wait) begin
                        n_strobe = '0;
                        n_phase  = PH_STROBE;
                    end else begin
                        n_strobe = r_strobe + 1'b1;
                    end
                end
                PH_STROBE: begin
                    if (r_strobe >= i_cfg.strobe_wait) begin
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                        n_err   = ERR_NONE;
                        if (n_written != '1) begin
                            n_written = n_written + 1'b1;
                        end
                    end else begin
                        n_strobe = r_strobe + 1'b1;
                    end
                end
                PH_ERRSLEEP: begin
                    n_sleep = slp;
                    if (slp >= delay) begin
                        if (i_item.cancel) begin
                            n_err   = ERR_INTR;
                            fin     = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_sleep = '0;
                            n_phase = PH_RETRYSLEEP;
                        end
                    end
                end
                PH_RETRYSLEEP: begin
                    n_sleep = slp;
                    if (slp >= delay) begin
                        n_poll  = '0;
                        n_phase = PH_POLL;
                    end
                end
                PH_RESET: begin
                    if (r_sleep != '1) begin
                        n_sleep = r_sleep + 1'b1;
                    end
                    init = 1'b1;
                    if (n_sleep >= PULSE_TICKS) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        drive = done || (n_phase == PH_SETUP) || (n_phase == PH_STROBE);

        n_res.data_lines    = drive ? n_held : '0;
        n_res.strobe_res    = (n_phase == PH_STROBE);
        n_res.init_low      = init;
        n_res.ready_res     = (n_phase == PH_IDLE);
        n_res.byte_done     = done;
        n_res.error_code    = n_err;
        n_res.finished      = fin;
        n_res.written_count = n_written;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_poll    <= '0;
            r_strobe  <= '0;
            r_sleep   <= '0;
            r_held    <= '0;
            r_written <= '0;
            r_err     <= ERR_NONE;
            r_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase   <= n_phase;
                r_poll    <= n_poll;
                r_strobe  <= n_strobe;
                r_sleep   <= n_sleep;
                r_held    <= n_held;
                r_written <= n_written;
                r_err     <= n_err;
                r_res     <= n_res;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid   <= 1'b0;
            end
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.byte_done |-> r_res.ready_res && !r_res.strobe_res
            && (r_res.error_code == ERR_NONE))
        else $error("byte_done without returning to idle");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.finished |-> r_res.ready_res && !r_res.byte_done
            && (r_res.error_code != ERR_NONE))
        else $error("finished without idle or error class");

    a_strobe_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.strobe_res |-> !r_res.ready_res && !r_res.init_low
            && (r_res.data_lines == r_held))
        else $error("strobe without held byte on data lines");

    a_reset_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && (i_item.cmd == CMD_RESET) |=> r_res.init_low && !r_res.strobe_res)
        else $error("reset command did not pull control lines low");

endmodule
